@@ sv/arc_cache_replacement_defines.svh @@
// assertion macros for the adaptive replacement cache block
`ifndef ARC_CACHE_REPLACEMENT_DEFINES_SVH
`define ARC_CACHE_REPLACEMENT_DEFINES_SVH

// condition that must hold at every clock edge out of reset
`define ARC_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// implication checked at the same clock edge
`define ARC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ sv/arc_pkg.sv @@
// shared types and constants for the adaptive replacement cache block
package arc_pkg;

    localparam int CAPACITY    = 64;
    localparam int DIR_ENTRIES = 128;
    localparam int TAG_BITS    = 32;
    localparam int STAMP_BITS  = 32;
    localparam int IDX_BITS    = $clog2(DIR_ENTRIES);
    localparam int CNT_BITS    = $clog2(DIR_ENTRIES + 1);
    localparam int P_BITS      = 7;
    localparam int STEP_BITS   = $clog2(CNT_BITS);

    // list codes
    localparam logic [1:0] L_T1 = 2'd0;
    localparam logic [1:0] L_T2 = 2'd1;
    localparam logic [1:0] L_B1 = 2'd2;
    localparam logic [1:0] L_B2 = 2'd3;

    // outcome codes
    localparam logic [1:0] OUT_MISS = 2'd0;
    localparam logic [1:0] OUT_HIT  = 2'd1;
    localparam logic [1:0] OUT_GB1  = 2'd2;
    localparam logic [1:0] OUT_GB2  = 2'd3;

    // register index of cache_size
    localparam logic REG_CACHE_SIZE = 1'b0;

    typedef struct packed {
        logic [1:0]            list;
        logic [STAMP_BITS-1:0] stamp;
    } t_meta;

    typedef struct packed {
        logic                start;
        logic [CNT_BITS-1:0] dividend;
        logic [CNT_BITS-1:0] divisor;
    } t_div_req;

endpackage

@@ sv/arc_cache_replacement.sv @@
// adaptive replacement cache policy engine, directory kept in on-chip memories
// the directory scan reads one entry per cycle over all 128 entries, then come drain and check,
// the divider wait on a ghost hit, the decision, the write-backs WR1 and WR2 and the result register
// throughput: one request at a time, next request taken as soon as the result is registered
// reset and cache_size writes clear valid bits, list counts, p and stamps
module arc_cache_replacement (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_page,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_outcome,
    output logic        o_evict_valid,
    output logic [31:0] o_evict_page,
    output logic [6:0]  o_target_t1,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import arc_pkg::*;
    `include "arc_cache_replacement_defines.svh"

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_DRAIN, S_CHECK, S_DIV, S_DECIDE, S_WR1, S_WR2, S_DONE
    } t_state;

    t_state r_state;

    // directory memories
    logic [TAG_BITS-1:0] mem_tag  [DIR_ENTRIES];
    t_meta               mem_meta [DIR_ENTRIES];
    logic [TAG_BITS-1:0] r_tag_q;
    t_meta               r_meta_q;
    logic                r_valid [DIR_ENTRIES];
    logic                r_vld_q;

    // control and policy state
    logic [6:0]            r_cache_size;
    logic [CNT_BITS-1:0]   r_cnt [4];
    logic [P_BITS-1:0]     r_p;
    logic [STAMP_BITS-1:0] r_stamp;
    logic [TAG_BITS-1:0]   r_tag;
    logic [IDX_BITS-1:0]   r_addr;
    logic                  r_rd_pend;
    logic [IDX_BITS-1:0]   r_rd_idx;

    // scan results
    logic                  r_hit;
    logic [IDX_BITS-1:0]   r_hit_idx;
    logic [1:0]            r_hit_list;
    logic                  r_free_vld;
    logic [IDX_BITS-1:0]   r_free_idx;
    logic                  r_lru_vld   [4];
    logic [IDX_BITS-1:0]   r_lru_idx   [4];
    logic [STAMP_BITS-1:0] r_lru_stamp [4];
    logic [TAG_BITS-1:0]   r_lru_tag   [4];

    // write-back plan
    logic                r_w1_vld;
    logic [IDX_BITS-1:0] r_w1_idx;
    t_meta               r_w1_meta;
    logic                r_w2_vld;
    logic [IDX_BITS-1:0] r_w2_idx;
    t_meta               r_w2_meta;
    logic                r_w2_tagwr;

    // result held until the output side is free
    logic                r_res_ev;
    logic [TAG_BITS-1:0] r_res_evp;
    logic [1:0]          r_res_outc;

    // output register
    logic        r_out_vld;
    logic [1:0]  r_out_outc;
    logic        r_out_ev;
    logic [31:0] r_out_evp;
    logic [6:0]  r_out_p;

    // divider
    t_div_req            div_req;
    logic                div_done;
    logic [CNT_BITS-1:0] div_quot;
    logic [CNT_BITS-1:0] r_quot;

    // decision results
    logic [CNT_BITS-1:0]   n_cnt [4];
    logic [P_BITS-1:0]     n_p;
    logic [STAMP_BITS-1:0] n_stamp;
    logic                  n_ev;
    logic [TAG_BITS-1:0]   n_evp;
    logic [1:0]            n_outc;
    logic                  n_w1_vld;
    logic [IDX_BITS-1:0]   n_w1_idx;
    t_meta                 n_w1_meta;
    logic                  n_w2_vld;
    logic [IDX_BITS-1:0]   n_w2_idx;
    t_meta                 n_w2_meta;
    logic                  n_w2_tagwr;
    logic                  n_drop_vld;
    logic [IDX_BITS-1:0]   n_drop_idx;
    logic [1:0]            n_drop_list;
    logic                  n_ins_vld;
    logic [IDX_BITS-1:0]   n_ins_idx;

    logic [P_BITS-1:0] c_eff;
    logic              cfg_wr;
    logic              hit_ghost;
    logic              ins_wr;
    logic [CNT_BITS+1:0] cnt_total;

    assign cfg_wr    = psel && penable && pwrite;
    assign hit_ghost = r_hit && (r_hit_list == L_B1 || r_hit_list == L_B2);
    assign ins_wr    = (r_state == S_WR2) && r_w2_vld && r_w2_tagwr;
    assign cnt_total = {2'b0, r_cnt[L_T1]} + {2'b0, r_cnt[L_T2]}
                     + {2'b0, r_cnt[L_B1]} + {2'b0, r_cnt[L_B2]};

    // effective cache size: zero acts as one, clamp to capacity
    always_comb begin
        if (r_cache_size == '0) begin
            c_eff = P_BITS'(1);
        end else if (r_cache_size > P_BITS'(CAPACITY)) begin
            c_eff = P_BITS'(CAPACITY);
        end else begin
            c_eff = r_cache_size;
        end
    end

    // divider request for ghost hits
    always_comb begin
        div_req.start    = (r_state == S_CHECK) && hit_ghost;
        div_req.dividend = (r_hit_list == L_B1) ? r_cnt[L_B2] : r_cnt[L_B1];
        div_req.divisor  = (r_hit_list == L_B1) ? r_cnt[L_B1] : r_cnt[L_B2];
    end

    arc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // policy decision from scan results
    always_comb begin
        logic [CNT_BITS-1:0]   v_d;
        logic [P_BITS+1:0]     v_psum;
        logic [CNT_BITS:0]     v_l1;
        logic [CNT_BITS:0]     v_l2;
        logic [CNT_BITS+1:0]   v_lsum;
        logic                  v_rep;
        logic                  v_inb2;
        logic                  v_first_t1;
        logic                  v_vic_vld;
        logic [1:0]            v_vic;
        logic [1:0]            v_vic_new;

        for (int k = 0; k < 4; k++) begin
            n_cnt[k] = r_cnt[k];
        end
        n_p         = r_p;
        n_stamp     = r_stamp;
        n_ev        = 1'b0;
        n_evp       = '0;
        n_outc      = OUT_MISS;
        n_w1_vld    = 1'b0;
        n_w1_idx    = r_lru_idx[L_T1];
        n_w1_meta   = '0;
        n_w2_vld    = 1'b0;
        n_w2_idx    = r_hit_idx;
        n_w2_meta   = '0;
        n_w2_tagwr  = 1'b0;
        n_drop_vld  = 1'b0;
        n_drop_idx  = r_lru_idx[L_B1];
        n_drop_list = L_B1;
        n_ins_vld   = 1'b0;
        n_ins_idx   = r_free_idx;
        v_rep       = 1'b0;
        v_inb2      = 1'b0;
        v_d         = (r_quot == '0) ? CNT_BITS'(1) : r_quot;
        v_psum      = {2'b0, r_p} + {1'b0, v_d};
        v_l1        = {1'b0, r_cnt[L_T1]} + {1'b0, r_cnt[L_B1]};
        v_l2        = {1'b0, r_cnt[L_T2]} + {1'b0, r_cnt[L_B2]};
        v_lsum      = {1'b0, v_l1} + {1'b0, v_l2};
        v_vic_vld   = 1'b0;
        v_vic       = L_T1;

        // classify and adapt p
        if (r_hit) begin
            unique case (r_hit_list)
                L_T1, L_T2: begin
                    n_outc = OUT_HIT;
                end
                L_B1: begin
                    n_outc = OUT_GB1;
                    n_p    = (v_psum > {2'b0, c_eff}) ? c_eff : v_psum[P_BITS-1:0];
                    v_rep  = 1'b1;
                end
                default: begin
                    n_outc = OUT_GB2;
                    n_p    = ({2'b0, r_p} > {1'b0, v_d})
                           ? P_BITS'({2'b0, r_p} - {1'b0, v_d}) : '0;
                    v_rep  = 1'b1;
                    v_inb2 = 1'b1;
                end
            endcase
        end else if (v_l1 == {2'b0, c_eff}) begin
            if (r_cnt[L_T1] < {1'b0, c_eff}) begin
                n_drop_vld  = r_lru_vld[L_B1];
                n_drop_idx  = r_lru_idx[L_B1];
                n_drop_list = L_B1;
                v_rep       = 1'b1;
            end else if (r_lru_vld[L_T1]) begin
                n_ev        = 1'b1;
                n_evp       = r_lru_tag[L_T1];
                n_drop_vld  = 1'b1;
                n_drop_idx  = r_lru_idx[L_T1];
                n_drop_list = L_T1;
            end
        end else if ((v_l1 < {2'b0, c_eff}) && (v_lsum >= {3'b0, c_eff})) begin
            if (v_lsum >= {2'b0, c_eff, 1'b0}) begin
                n_drop_vld  = r_lru_vld[L_B2];
                n_drop_idx  = r_lru_idx[L_B2];
                n_drop_list = L_B2;
            end
            v_rep = 1'b1;
        end

        // replace: move the chosen resident lru into its ghost list
        v_first_t1 = (r_cnt[L_T1] != '0)
                   && ((v_inb2 && r_cnt[L_T1] == {1'b0, n_p})
                       || (r_cnt[L_T1] > {1'b0, n_p}));
        if (v_rep) begin
            if (v_first_t1) begin
                v_vic_vld = r_lru_vld[L_T1] || r_lru_vld[L_T2];
                v_vic     = r_lru_vld[L_T1] ? L_T1 : L_T2;
            end else begin
                v_vic_vld = r_lru_vld[L_T2] || r_lru_vld[L_T1];
                v_vic     = r_lru_vld[L_T2] ? L_T2 : L_T1;
            end
        end
        v_vic_new = (v_vic == L_T1) ? L_B1 : L_B2;
        if (v_vic_vld) begin
            n_ev            = 1'b1;
            n_evp           = r_lru_tag[v_vic];
            n_w1_vld        = 1'b1;
            n_w1_idx        = r_lru_idx[v_vic];
            n_w1_meta.list  = v_vic_new;
            n_w1_meta.stamp = n_stamp;
            n_stamp         = n_stamp + 1'b1;
            n_cnt[v_vic]     = n_cnt[v_vic] - 1'b1;
            n_cnt[v_vic_new] = n_cnt[v_vic_new] + 1'b1;
        end

        // dropped ghost or resident entry leaves the directory
        if (n_drop_vld) begin
            n_cnt[n_drop_list] = n_cnt[n_drop_list] - 1'b1;
        end

        // requested page becomes mru of t2, or is inserted into t1
        if (r_hit) begin
            n_w2_vld        = 1'b1;
            n_w2_idx        = r_hit_idx;
            n_w2_meta.list  = L_T2;
            n_w2_meta.stamp = n_stamp;
            n_stamp         = n_stamp + 1'b1;
            n_cnt[r_hit_list] = n_cnt[r_hit_list] - 1'b1;
            n_cnt[L_T2]       = n_cnt[L_T2] + 1'b1;
        end else begin
            if (n_drop_vld && (!r_free_vld || n_drop_idx < r_free_idx)) begin
                n_ins_vld = 1'b1;
                n_ins_idx = n_drop_idx;
            end else if (r_free_vld) begin
                n_ins_vld = 1'b1;
                n_ins_idx = r_free_idx;
            end
            if (n_ins_vld) begin
                n_w2_vld        = 1'b1;
                n_w2_idx        = n_ins_idx;
                n_w2_meta.list  = L_T1;
                n_w2_meta.stamp = n_stamp;
                n_w2_tagwr      = 1'b1;
                n_stamp         = n_stamp + 1'b1;
                n_cnt[L_T1]     = n_cnt[L_T1] + 1'b1;
            end
        end
    end

    // tag memory: scan read, insert write
    always_ff @(posedge i_clk) begin
        if (ins_wr) begin
            mem_tag[r_w2_idx] <= r_tag;
        end
        r_tag_q <= mem_tag[r_addr];
    end

    // list and stamp memory: scan read, write-back of moved entries
    always_ff @(posedge i_clk) begin
        if (r_state == S_WR1 && r_w1_vld) begin
            mem_meta[r_w1_idx] <= r_w1_meta;
        end else if (r_state == S_WR2 && r_w2_vld) begin
            mem_meta[r_w2_idx] <= r_w2_meta;
        end
        r_meta_q <= mem_meta[r_addr];
    end

    // sequencer, scan accumulation, policy state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cache_size <= 7'(CAPACITY);
            r_p          <= '0;
            r_stamp      <= '0;
            r_rd_pend    <= 1'b0;
            r_out_vld    <= 1'b0;
            for (int k = 0; k < DIR_ENTRIES; k++) begin
                r_valid[k] <= 1'b0;
            end
            for (int k = 0; k < 4; k++) begin
                r_cnt[k] <= '0;
            end
        end else begin
            // scan read pipeline
            r_rd_pend <= (r_state == S_SCAN);
            r_rd_idx  <= r_addr;
            r_vld_q   <= r_valid[r_addr];

            if (r_out_vld && i_ready && r_state != S_DONE) begin
                r_out_vld <= 1'b0;
            end

            // evaluate one directory entry per cycle
            if (r_rd_pend) begin
                if (r_vld_q) begin
                    if (!r_hit && r_tag_q == r_tag) begin
                        r_hit      <= 1'b1;
                        r_hit_idx  <= r_rd_idx;
                        r_hit_list <= r_meta_q.list;
                    end
                    if (!r_lru_vld[r_meta_q.list]
                        || r_meta_q.stamp < r_lru_stamp[r_meta_q.list]) begin
                        r_lru_vld[r_meta_q.list]   <= 1'b1;
                        r_lru_idx[r_meta_q.list]   <= r_rd_idx;
                        r_lru_stamp[r_meta_q.list] <= r_meta_q.stamp;
                        r_lru_tag[r_meta_q.list]   <= r_tag_q;
                    end
                end else if (!r_free_vld) begin
                    r_free_vld <= 1'b1;
                    r_free_idx <= r_rd_idx;
                end
            end

            unique case (r_state)
                S_IDLE: begin
                    if (cfg_wr && paddr[2] == REG_CACHE_SIZE) begin
                        r_cache_size <= pwdata[6:0];
                        r_p          <= '0;
                        r_stamp      <= '0;
                        for (int k = 0; k < DIR_ENTRIES; k++) begin
                            r_valid[k] <= 1'b0;
                        end
                        for (int k = 0; k < 4; k++) begin
                            r_cnt[k] <= '0;
                        end
                    end else if (i_valid && !cfg_wr) begin
                        r_tag      <= i_page;
                        r_addr     <= '0;
                        r_hit      <= 1'b0;
                        r_hit_list <= L_T1;
                        r_free_vld <= 1'b0;
                        r_quot     <= '0;
                        for (int k = 0; k < 4; k++) begin
                            r_lru_vld[k] <= 1'b0;
                        end
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_addr == IDX_BITS'(DIR_ENTRIES - 1)) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    r_state <= hit_ghost ? S_DIV : S_DECIDE;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_quot  <= div_quot;
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    for (int k = 0; k < 4; k++) begin
                        r_cnt[k] <= n_cnt[k];
                    end
                    r_p        <= n_p;
                    r_stamp    <= n_stamp;
                    r_res_ev   <= n_ev;
                    r_res_evp  <= n_evp;
                    r_res_outc <= n_outc;
                    r_w1_vld   <= n_w1_vld;
                    r_w1_idx   <= n_w1_idx;
                    r_w1_meta  <= n_w1_meta;
                    r_w2_vld   <= n_w2_vld;
                    r_w2_idx   <= n_w2_idx;
                    r_w2_meta  <= n_w2_meta;
                    r_w2_tagwr <= n_w2_tagwr;
                    // a dropped slot that is reused for the insert stays valid
                    if (n_drop_vld && !(n_ins_vld && n_ins_idx == n_drop_idx)) begin
                        r_valid[n_drop_idx] <= 1'b0;
                    end
                    if (n_ins_vld) begin
                        r_valid[n_ins_idx] <= 1'b1;
                    end
                    r_state <= S_WR1;
                end
                S_WR1: begin
                    r_state <= S_WR2;
                end
                S_WR2: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_vld || i_ready) begin
                        r_out_vld  <= 1'b1;
                        r_out_outc <= r_res_outc;
                        r_out_ev   <= r_res_ev;
                        r_out_evp  <= r_res_ev ? r_res_evp[31:0] : 32'd0;
                        r_out_p    <= r_p;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready       = (r_state == S_IDLE) && !cfg_wr;
    assign o_valid       = r_out_vld;
    assign o_outcome     = r_out_outc;
    assign o_evict_valid = r_out_ev;
    assign o_evict_page  = r_out_evp;
    assign o_target_t1   = r_out_p;
    assign pready        = 1'b1;
    assign prdata        = (paddr[2] == REG_CACHE_SIZE) ? {25'd0, r_cache_size} : 32'd0;

    // directory never holds more entries than it has
    `ARC_ASSERT(a_count_bound, (cnt_total <= 10'(DIR_ENTRIES)), "list counts exceed directory size")
    // an inserted entry is already marked valid when its tag is written
    `ARC_ASSERT_IMP(a_insert_valid, ins_wr, r_valid[r_w2_idx], "insert slot not valid")
    // no eviction reported means the evicted page field is zero
    `ARC_ASSERT_IMP(a_evict_zero, r_out_vld && !r_out_ev, r_out_evp == '0, "stray evict page")
    // divider finishes only while the sequencer waits for it
    `ARC_ASSERT_IMP(a_div_state, div_done, (r_state == S_DIV), "divider result outside wait state")

endmodule

@@ sv/arc_div.sv @@
// restoring divider for the ghost-hit adaptation step, one quotient bit per cycle
module arc_div (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  arc_pkg::t_div_req        i_req,
    output logic                     o_done,
    output logic [arc_pkg::CNT_BITS-1:0] o_quot
);
    import arc_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [STEP_BITS-1:0] r_step;
    logic [CNT_BITS-1:0]  r_rem;
    logic [CNT_BITS-1:0]  r_dvd;
    logic [CNT_BITS-1:0]  r_dvs;
    logic [CNT_BITS-1:0]  r_quot;
    logic [CNT_BITS:0]    n_shift;
    logic [CNT_BITS:0]    n_rem;
    logic                 n_bit;

    // one shift-subtract step
    always_comb begin
        n_shift = {r_rem, r_dvd[CNT_BITS-1]};
        n_bit   = (n_shift >= {1'b0, r_dvs});
        n_rem   = n_bit ? (n_shift - {1'b0, r_dvs}) : n_shift;
    end

    // iteration control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= STEP_BITS'(CNT_BITS - 1);
                r_rem  <= '0;
                r_dvd  <= i_req.dividend;
                r_dvs  <= i_req.divisor;
                r_quot <= '0;
            end else if (r_busy) begin
                r_rem  <= n_rem[CNT_BITS-1:0];
                r_dvd  <= {r_dvd[CNT_BITS-2:0], 1'b0};
                r_quot <= {r_quot[CNT_BITS-2:0], n_bit};
                r_step <= r_step - 1'b1;
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule
